### rtl/core/sfa_pkg.sv
// Package for the secp256k1 field ALU: prime, inversion exponent, opcodes, state codes.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package sfa_pkg;

  localparam int unsigned FieldW = 256;
  localparam int unsigned LimbW  = 64;

  // p = 2^256 - 2^32 - 977
  localparam logic [FieldW-1:0] FieldP =
    256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_FFFFFC2F;

  // Exponent p-2 for inversion by Fermat
  localparam logic [FieldW-1:0] ExpPm2 =
    256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_FFFFFC2D;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_INV = 2'd3
  } op_e;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_NORMA = 7'b0000010,
    S_NORMB = 7'b0000100,
    S_DISP  = 7'b0001000,
    S_MDBL  = 7'b0010000,
    S_MADD  = 7'b0100000,
    S_MEND  = 7'b1000000
  } state_e;

endpackage
`default_nettype wire

### rtl/core/sfa_addsub.sv
// Shared modular add/subtract unit: (x + y) mod p or (x - y) mod p.
// Depends on sfa_pkg. Add accepts x below 2^256 with y = 0 to reduce an operand.
`timescale 1ns / 1ps
`default_nettype none
module sfa_addsub import sfa_pkg::*; (
  input  wire logic [FieldW-1:0] x_i,
  input  wire logic [FieldW-1:0] y_i,
  input  wire logic              sub_i,
  output logic      [FieldW-1:0] res_o
);

  logic [FieldW:0]   sum;
  logic [FieldW+1:0] sum_mp;
  logic [FieldW:0]   diff;
  logic [FieldW-1:0] diff_pp;

  // add path: subtract p when the sum reaches it
  assign sum    = {1'b0, x_i} + {1'b0, y_i};
  assign sum_mp = {1'b0, sum} - {2'b00, FieldP};

  // subtract path: add p back on borrow
  assign diff    = {1'b0, x_i} - {1'b0, y_i};
  assign diff_pp = diff[FieldW-1:0] + FieldP;

  always_comb begin
    if (sub_i) begin
      res_o = diff[FieldW] ? diff_pp : diff[FieldW-1:0];
    end else begin
      res_o = sum_mp[FieldW+1] ? sum[FieldW-1:0] : sum_mp[FieldW-1:0];
    end
  end

endmodule
`default_nettype wire

### rtl/core/secp256k1_field_alu_top.sv
// Top level of the secp256k1 field ALU: sequencer, operand registers, result register.
// Depends on sfa_pkg and sfa_addsub.
`timescale 1ns / 1ps
`default_nettype none
// Raise start_i while busy_o is low to transfer an opcode and two 256-bit operands; the
// result appears on r_limb*_o for exactly one cycle with valid_o high and cannot be stalled.
// Results are always fully reduced below p; operands at or above p are reduced first, and
// the inverse of zero is zero. All work runs through one 256-bit modular add/subtract unit,
// one operation per cycle. Add and subtract pass through S_NORMA, S_NORMB and S_DISP to the
// result. Multiply is double-and-add over the 256 multiplier bits, with a doubling pass in
// S_MDBL and an adding pass in S_MADD per bit. Invert raises the operand to p-2 by
// square-and-multiply with 249 extra multiplies, 505 multiplies in all. busy_o stays high
// for the whole operation.
module secp256k1_field_alu_top import sfa_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire logic [1:0]       opcode_i,
  input  wire logic [LimbW-1:0] a_limb0_i,
  input  wire logic [LimbW-1:0] a_limb1_i,
  input  wire logic [LimbW-1:0] a_limb2_i,
  input  wire logic [LimbW-1:0] a_limb3_i,
  input  wire logic [LimbW-1:0] b_limb0_i,
  input  wire logic [LimbW-1:0] b_limb1_i,
  input  wire logic [LimbW-1:0] b_limb2_i,
  input  wire logic [LimbW-1:0] b_limb3_i,
  output logic                  valid_o,
  output logic      [LimbW-1:0] r_limb0_o,
  output logic      [LimbW-1:0] r_limb1_o,
  output logic      [LimbW-1:0] r_limb2_o,
  output logic      [LimbW-1:0] r_limb3_o
);

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic              valid_q, valid_d;
  logic              sq_q, sq_d;
  logic [7:0]        mcnt_q, mcnt_d;
  logic [7:0]        ecnt_q, ecnt_d;
  logic [FieldW-1:0] a_q, a_d;
  logic [FieldW-1:0] b_q, b_d;
  logic [FieldW-1:0] x_q, x_d;
  logic [FieldW-1:0] y_q, y_d;
  logic [FieldW-1:0] r_q, r_d;
  logic [FieldW-1:0] res_q, res_d;

  logic [FieldW-1:0] ux, uy, ures;
  logic              usub;
  logic              start_ok;

  assign start_ok = start_i && (state_q == S_IDLE);

  sfa_addsub u_addsub (
    .x_i  (ux),
    .y_i  (uy),
    .sub_i(usub),
    .res_o(ures)
  );

  // operand select for the shared unit
  always_comb begin
    ux   = r_q;
    uy   = '0;
    usub = 1'b0;
    case (state_q)
      S_NORMA: ux = a_q;
      S_NORMB: ux = b_q;
      S_DISP: begin
        ux   = a_q;
        uy   = b_q;
        usub = (op_q == OP_SUB);
      end
      S_MDBL:  uy = r_q;
      S_MADD:  uy = x_q[FieldW-1] ? y_q : '0;
      default: ux = r_q;
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    valid_d = 1'b0;
    sq_d    = sq_q;
    mcnt_d  = mcnt_q;
    ecnt_d  = ecnt_q;
    a_d     = a_q;
    b_d     = b_q;
    x_d     = x_q;
    y_d     = y_q;
    r_d     = r_q;
    res_d   = res_q;
    case (state_q)
      S_IDLE: begin
        if (start_ok) begin
          op_d    = op_e'(opcode_i);
          a_d     = {a_limb3_i, a_limb2_i, a_limb1_i, a_limb0_i};
          b_d     = {b_limb3_i, b_limb2_i, b_limb1_i, b_limb0_i};
          state_d = S_NORMA;
        end
      end
      S_NORMA: begin
        a_d     = ures;
        state_d = S_NORMB;
      end
      S_NORMB: begin
        b_d     = ures;
        state_d = S_DISP;
      end
      S_DISP: begin
        mcnt_d = 8'hFF;
        r_d    = '0;
        case (op_q)
          OP_ADD, OP_SUB: begin
            res_d   = ures;
            valid_d = 1'b1;
            state_d = S_IDLE;
          end
          OP_MUL: begin
            x_d     = a_q;
            y_d     = b_q;
            state_d = S_MDBL;
          end
          default: begin
            // invert: start from 1 and square first
            x_d     = {{(FieldW-1){1'b0}}, 1'b1};
            y_d     = {{(FieldW-1){1'b0}}, 1'b1};
            ecnt_d  = 8'hFF;
            sq_d    = 1'b1;
            state_d = S_MDBL;
          end
        endcase
      end
      S_MDBL: begin
        r_d     = ures;
        state_d = S_MADD;
      end
      S_MADD: begin
        r_d = ures;
        x_d = {x_q[FieldW-2:0], 1'b0};
        if (mcnt_q == 8'd0) begin
          state_d = S_MEND;
        end else begin
          mcnt_d  = mcnt_q - 8'd1;
          state_d = S_MDBL;
        end
      end
      S_MEND: begin
        mcnt_d = 8'hFF;
        if (op_q == OP_MUL) begin
          res_d   = r_q;
          valid_d = 1'b1;
          state_d = S_IDLE;
        end else if (sq_q && ExpPm2[ecnt_q]) begin
          // multiply the square by the operand
          x_d     = r_q;
          y_d     = a_q;
          r_d     = '0;
          sq_d    = 1'b0;
          state_d = S_MDBL;
        end else if (ecnt_q == 8'd0) begin
          res_d   = r_q;
          valid_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          ecnt_d  = ecnt_q - 8'd1;
          x_d     = r_q;
          y_d     = r_q;
          r_d     = '0;
          sq_d    = 1'b1;
          state_d = S_MDBL;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
      op_q    <= OP_ADD;
      sq_q    <= 1'b0;
      mcnt_q  <= '0;
      ecnt_q  <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      op_q    <= op_d;
      sq_q    <= sq_d;
      mcnt_q  <= mcnt_d;
      ecnt_q  <= ecnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    x_q   <= x_d;
    y_q   <= y_d;
    r_q   <= r_d;
    res_q <= res_d;
  end

  assign busy_o    = (state_q != S_IDLE);
  assign valid_o   = valid_q;
  assign r_limb0_o = res_q[LimbW-1:0];
  assign r_limb1_o = res_q[2*LimbW-1:LimbW];
  assign r_limb2_o = res_q[3*LimbW-1:2*LimbW];
  assign r_limb3_o = res_q[4*LimbW-1:3*LimbW];

  // checks
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_ok |=> busy_o) else $error("transfer did not raise busy");

  a_madd_after_dbl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MADD) |-> $past(state_q == S_MDBL)) else $error("add step out of order");

  a_valid_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |=> !valid_q) else $error("result strobe repeated");

  a_result_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (res_q < FieldP)) else $error("result not reduced");

endmodule
`default_nettype wire
